FILE: rtl/core/pafs_pkg.sv
// Shared types, constants and helpers for the page access frequency statistics block.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package pafs_pkg;

  // build-time sizes
  localparam int BUCKETS   = 16;
  localparam int NODES     = 8;
  localparam int FREQ_BITS = 8;

  // port widths fixed by the word format
  localparam int FREQ_W    = 8;
  localparam int NODE_W    = 3;
  localparam int BIDX_W    = 4;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 40;
  localparam int THR_W     = 16;
  localparam int LNC_W     = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_NODE_COUNT = 1'b1;

  // input operations and result kinds
  localparam logic OP_RECORD      = 1'b0;
  localparam logic OP_READ_BUCKET = 1'b1;
  localparam logic KIND_STATS     = 1'b0;
  localparam logic KIND_BUCKET    = 1'b1;

  // frequencies are held to FREQ_BITS; also the minimum after a clear
  localparam logic [FREQ_W-1:0] FREQ_MASK = FREQ_W'((1 << FREQ_BITS) - 1);

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [FREQ_W-1:0] freq_t;

  // one record update, decoded in the top level
  typedef struct packed {
    logic  en;       // a page record is being applied this cycle
    logic  first;    // clear everything before counting
    logic  hist_en;  // record goes into the histogram
    freq_t freq;     // masked frequency
    logic  white;
    logic  hot;
  } upd_t;

  // run figures as they stand after the current record
  typedef struct packed {
    cnt_t  page_count;
    freq_t max_freq;
    freq_t min_freq;
    cnt_t  nonzero_count;
    sum_t  freq_total;
    cnt_t  zero_count;
    cnt_t  hot_count;
    cnt_t  white_count;
  } stats_t;

  // saturating counter step
  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

FILE: rtl/core/pafs_hist.sv
// Frequency histogram: one saturating counter per bucket, top bucket clamps.
// Depends on pafs_pkg for sizes, update word and sat_inc.
`timescale 1ns / 1ps

module pafs_hist (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pafs_pkg::upd_t          upd,
  input  logic [pafs_pkg::BIDX_W-1:0] rd_index,
  output pafs_pkg::cnt_t          rd_value
);
  import pafs_pkg::*;

  cnt_t hist_r   [BUCKETS];
  cnt_t hist_nxt [BUCKETS];

  // each bucket decides on its own whether this record lands in it
  always_comb begin
    logic hit;
    cnt_t base;
    for (int i = 0; i < BUCKETS; i++) begin
      if (i < BUCKETS - 1) begin
        hit = upd.hist_en && (int'(upd.freq) == i);
      end else begin
        hit = upd.hist_en && (int'(upd.freq) >= BUCKETS - 1);
      end
      base = upd.first ? '0 : hist_r[i];
      hist_nxt[i] = hit ? sat_inc(base) : base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUCKETS; i++) hist_r[i] <= '0;
    end else if (upd.en) begin
      for (int i = 0; i < BUCKETS; i++) hist_r[i] <= hist_nxt[i];
    end
  end

  // readout mux, indexes past the last bucket read as zero
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < BUCKETS; i++) begin
      if (int'(rd_index) == i) rd_value = hist_r[i];
    end
  end

  // a first record kept out of the histogram leaves the buckets empty
  a_clear_on_first: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.en && upd.first && !upd.hist_en) |=> (hist_r[0] == '0))
    else $error("histogram not cleared by first record");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !upd.en |=> (hist_r[BUCKETS-1] == $past(hist_r[BUCKETS-1])))
    else $error("histogram changed without a record");

  a_readout_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(rd_index) >= BUCKETS) |-> (rd_value == '0))
    else $error("out of range bucket read non-zero");

endmodule

FILE: rtl/core/pafs_stats.sv
// Scalar run figures: extremes, counts and the saturating frequency sum.
// Depends on pafs_pkg for the update and figures structs.
`timescale 1ns / 1ps

module pafs_stats (
  input  logic             clk,
  input  logic             rst_n,
  input  pafs_pkg::upd_t   upd,
  output pafs_pkg::stats_t stats_nxt
);
  import pafs_pkg::*;

  stats_t stats_r;
  stats_t base;
  logic [SUM_W:0] sum_wide;
  logic           nz;

  // figures the record is added to: cleared ones on the first record of a run
  always_comb begin
    if (upd.first) begin
      base               = '0;
      base.min_freq      = FREQ_MASK;
    end else begin
      base = stats_r;
    end
  end

  // apply the record
  always_comb begin
    nz       = (upd.freq != '0);
    sum_wide = {1'b0, base.freq_total} + (SUM_W + 1)'(upd.freq);

    stats_nxt               = base;
    stats_nxt.page_count    = sat_inc(base.page_count);
    stats_nxt.max_freq      = (upd.freq > base.max_freq) ? upd.freq : base.max_freq;
    stats_nxt.min_freq      = (upd.freq < base.min_freq) ? upd.freq : base.min_freq;
    if (nz) begin
      stats_nxt.nonzero_count = sat_inc(base.nonzero_count);
      stats_nxt.freq_total    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end else begin
      stats_nxt.zero_count    = sat_inc(base.zero_count);
    end
    if (upd.hot)   stats_nxt.hot_count   = sat_inc(base.hot_count);
    if (upd.white) stats_nxt.white_count = sat_inc(base.white_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r          <= '0;
      stats_r.min_freq <= FREQ_MASK;
    end else if (upd.en) begin
      stats_r <= stats_nxt;
    end
  end

  // extremes stay ordered once a page has been seen
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (stats_r.page_count != '0) |-> (stats_r.min_freq <= stats_r.max_freq))
    else $error("min frequency above max frequency");

  // no sum without a nonzero page
  a_sum_needs_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (stats_r.nonzero_count == '0) |-> (stats_r.freq_total == '0))
    else $error("frequency sum without nonzero pages");

  // zero and nonzero counts stay empty while no page has been counted
  a_pages_split: assert property (@(posedge clk) disable iff (!rst_n)
    (stats_r.page_count == '0) |->
      (stats_r.zero_count == '0 && stats_r.nonzero_count == '0))
    else $error("counts without pages");

endmodule

FILE: rtl/core/page_access_frequency_stats.sv
// Top level of the page access frequency statistics block: input register,
// record decode, result register. Depends on pafs_pkg, pafs_hist, pafs_stats.
//
//   port group | direction | handshake            | word
//   in_*       | in        | in_valid / in_stall   | op, node, freq, white, first, last, bucket
//   out_*      | out       | out_valid / out_stall | kind and run figures or bucket value
//   cfg_*      | in        | cfg_we                | hot threshold, local node count
//
// One word per cycle while in_stall is low; a result word passes the input register,
// then the result register. The rate is set by the single update stage between them.
// Synchronous active-low reset clears all figures, histogram, configuration and both valid bits.
// The input stalls only while the input register holds a word that produces a result
// and the result register is still held; other records keep flowing.
`timescale 1ns / 1ps

module page_access_frequency_stats (
  input  logic                           clk,
  input  logic                           rst_n,
  // input words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [pafs_pkg::NODE_W-1:0]    in_node,
  input  logic [pafs_pkg::FREQ_W-1:0]    in_freq,
  input  logic                           in_white,
  input  logic                           in_first,
  input  logic                           in_last,
  input  logic [pafs_pkg::BIDX_W-1:0]    in_bucket_index,
  // result words
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic [pafs_pkg::CNT_W-1:0]     out_page_count,
  output logic [pafs_pkg::FREQ_W-1:0]    out_max_freq,
  output logic [pafs_pkg::FREQ_W-1:0]    out_min_freq,
  output logic [pafs_pkg::CNT_W-1:0]     out_nonzero_count,
  output logic [pafs_pkg::SUM_W-1:0]     out_freq_total,
  output logic [pafs_pkg::CNT_W-1:0]     out_zero_count,
  output logic [pafs_pkg::CNT_W-1:0]     out_hot_count,
  output logic [pafs_pkg::CNT_W-1:0]     out_white_count,
  output logic [pafs_pkg::CNT_W-1:0]     out_bucket_value,
  // configuration
  input  logic                           cfg_we,
  input  logic [pafs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pafs_pkg::CFG_W-1:0]     cfg_data
);
  import pafs_pkg::*;

  // configuration registers
  logic [THR_W-1:0] hot_threshold_r;
  logic [LNC_W-1:0] local_node_count_r;

  // input register
  logic              in_v_r;
  logic              op_r;
  logic [NODE_W-1:0] node_r;
  freq_t             freq_r;
  logic              white_r;
  logic              first_r;
  logic              last_r;
  logic [BIDX_W-1:0] bidx_r;

  // result register
  logic   out_v_r;
  logic   kind_r;
  stats_t res_r;
  cnt_t   bucket_r;

  logic   has_result;
  logic   out_free;
  logic   fire;
  logic   load_in;
  upd_t   upd;
  stats_t stats_nxt;
  cnt_t   rd_value;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_threshold_r    <= '0;
      local_node_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOT_THRESHOLD:    hot_threshold_r    <= cfg_data[THR_W-1:0];
        CFG_LOCAL_NODE_COUNT: local_node_count_r <= cfg_data[LNC_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake between input register, update stage and result register
  assign has_result = (op_r == OP_READ_BUCKET) || last_r;
  assign out_free   = !out_v_r || !out_stall;
  assign fire       = in_v_r && (!has_result || out_free);
  assign in_stall   = in_v_r && !fire;
  assign load_in    = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (load_in) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      op_r    <= in_op;
      node_r  <= in_node;
      freq_r  <= in_freq & FREQ_MASK;
      white_r <= in_white;
      first_r <= in_first;
      last_r  <= in_last;
      bidx_r  <= in_bucket_index;
    end
  end

  // record decode
  always_comb begin
    upd.en      = fire && (op_r == OP_RECORD);
    upd.first   = first_r;
    upd.hist_en = (LNC_W'(node_r) >= local_node_count_r) || !white_r;
    upd.freq    = freq_r;
    upd.white   = white_r;
    upd.hot     = (THR_W'(freq_r) >= hot_threshold_r);
  end

  pafs_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (upd),
    .rd_index (bidx_r),
    .rd_value (rd_value)
  );

  pafs_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .stats_nxt (stats_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      priority if (fire && has_result) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      if (op_r == OP_READ_BUCKET) begin
        kind_r   <= KIND_BUCKET;
        res_r    <= '0;
        bucket_r <= rd_value;
      end else begin
        kind_r   <= KIND_STATS;
        res_r    <= stats_nxt;
        bucket_r <= '0;
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_kind          = kind_r;
  assign out_page_count    = res_r.page_count;
  assign out_max_freq      = res_r.max_freq;
  assign out_min_freq      = res_r.min_freq;
  assign out_nonzero_count = res_r.nonzero_count;
  assign out_freq_total    = res_r.freq_total;
  assign out_zero_count    = res_r.zero_count;
  assign out_hot_count     = res_r.hot_count;
  assign out_white_count   = res_r.white_count;
  assign out_bucket_value  = bucket_r;

  // a word that produces a result always shows up on the output next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && has_result) |=> out_v_r)
    else $error("result word lost");

  // only a full input register can hold off the sender
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && has_result && out_v_r && out_stall))
    else $error("input stalled without cause");

  // reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !in_v_r))
    else $error("registers not empty after reset");

endmodule

FILE: tb/page_access_frequency_stats_tb.sv
// Self-checking testbench for page_access_frequency_stats: run statistics and bucket readouts
// checked against an in-bench prediction of the histogram and run figures.
// Depends on pafs_pkg and the page_access_frequency_stats RTL only.
`timescale 1ns / 1ps

module page_access_frequency_stats_tb;
  import pafs_pkg::*;

  localparam int RANDOM_WORDS  = 1100;
  localparam int PHASES        = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 5000;

  // one input word as the sender offers it
  typedef struct packed {
    logic              op;
    logic [NODE_W-1:0] node;
    freq_t             freq;
    logic              white;
    logic              first;
    logic              last;
    logic [BIDX_W-1:0] bidx;
  } page_word_t;

  // one result word
  typedef struct packed {
    logic  kind;
    cnt_t  page_count;
    freq_t max_freq;
    freq_t min_freq;
    cnt_t  nonzero_count;
    sum_t  freq_total;
    cnt_t  zero_count;
    cnt_t  hot_count;
    cnt_t  white_count;
    cnt_t  bucket_value;
  } figures_t;

  // tracks histogram and run figures, holds the result words still due
  class freq_stats_scoreboard;
    cnt_t              hist [BUCKETS];
    freq_t             top_freq;
    freq_t             low_freq;
    cnt_t              nonzero_pages;
    sum_t              freq_sum;
    cnt_t              zero_pages;
    cnt_t              hot_pages;
    cnt_t              white_pages;
    cnt_t              page_total;
    logic [THR_W-1:0]  hot_level;
    logic [LNC_W-1:0]  local_nodes;
    figures_t          pending_figures [$];
    int                faults;
    int                words_in;
    int                runs_begun;
    int                stats_checked;
    int                readouts_checked;

    function new();
      hot_level   = '0;
      local_nodes = '0;
      clear_run();
    endfunction

    function void clear_run();
      foreach (hist[i]) hist[i] = '0;
      top_freq      = '0;
      low_freq      = FREQ_MASK;
      nonzero_pages = '0;
      freq_sum      = '0;
      zero_pages    = '0;
      hot_pages     = '0;
      white_pages   = '0;
      page_total    = '0;
    endfunction

    static function cnt_t bump(cnt_t v);
      return (&v) ? v : v + cnt_t'(1);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_HOT_THRESHOLD) hot_level = val[THR_W-1:0];
      else if (idx == CFG_LOCAL_NODE_COUNT) local_nodes = val[LNC_W-1:0];
    endfunction

    // apply one accepted word; queue the result word it causes, if any
    function void note_word(page_word_t w);
      figures_t     f;
      freq_t        fq;
      int           slot;
      logic [SUM_W:0] wide_sum;
      f = '0;
      words_in++;
      if (w.op == OP_READ_BUCKET) begin
        f.kind = KIND_BUCKET;
        f.bucket_value = (w.bidx < BUCKETS) ? hist[w.bidx] : '0;
        pending_figures.push_back(f);
        return;
      end
      if (w.first) begin
        clear_run();
        runs_begun++;
      end
      fq = w.freq & FREQ_MASK;
      // top bucket collects every larger frequency
      slot = (fq < BUCKETS - 1) ? int'(fq) : BUCKETS - 1;
      // whitelisted pages on local nodes stay out of the histogram
      if (LNC_W'(w.node) >= local_nodes || !w.white) hist[slot] = bump(hist[slot]);
      if (fq != '0) begin
        nonzero_pages = bump(nonzero_pages);
        wide_sum = {1'b0, freq_sum} + (SUM_W + 1)'(fq);
        freq_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
      end else begin
        zero_pages = bump(zero_pages);
      end
      if (THR_W'(fq) >= hot_level) hot_pages = bump(hot_pages);
      if (w.white) white_pages = bump(white_pages);
      page_total = bump(page_total);
      if (fq > top_freq) top_freq = fq;
      if (fq < low_freq) low_freq = fq;
      if (!w.last) return;
      f.kind          = KIND_STATS;
      f.page_count    = page_total;
      f.max_freq      = top_freq;
      f.min_freq      = low_freq;
      f.nonzero_count = nonzero_pages;
      f.freq_total    = freq_sum;
      f.zero_count    = zero_pages;
      f.hot_count     = hot_pages;
      f.white_count   = white_pages;
      pending_figures.push_back(f);
    endfunction

    task report(string msg);
      faults++;
      if (faults <= 40) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task cmp_field(string name, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
      if (got !== want)
        report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_word(figures_t got);
      figures_t want;
      if (pending_figures.size() == 0) begin
        report($sformatf("result word with nothing expected, kind %0b", got.kind));
        return;
      end
      want = pending_figures.pop_front();
      if (want.kind == KIND_BUCKET) readouts_checked++;
      else stats_checked++;
      cmp_field("kind", SUM_W'(got.kind), SUM_W'(want.kind));
      cmp_field("page_count", SUM_W'(got.page_count), SUM_W'(want.page_count));
      cmp_field("max_freq", SUM_W'(got.max_freq), SUM_W'(want.max_freq));
      cmp_field("min_freq", SUM_W'(got.min_freq), SUM_W'(want.min_freq));
      cmp_field("nonzero_count", SUM_W'(got.nonzero_count), SUM_W'(want.nonzero_count));
      cmp_field("freq_total", got.freq_total, want.freq_total);
      cmp_field("zero_count", SUM_W'(got.zero_count), SUM_W'(want.zero_count));
      cmp_field("hot_count", SUM_W'(got.hot_count), SUM_W'(want.hot_count));
      cmp_field("white_count", SUM_W'(got.white_count), SUM_W'(want.white_count));
      cmp_field("bucket_value", SUM_W'(got.bucket_value), SUM_W'(want.bucket_value));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_op;
  logic [NODE_W-1:0]    in_node;
  freq_t                in_freq;
  logic                 in_white;
  logic                 in_first;
  logic                 in_last;
  logic [BIDX_W-1:0]    in_bucket_index;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_kind;
  cnt_t                 out_page_count;
  freq_t                out_max_freq;
  freq_t                out_min_freq;
  cnt_t                 out_nonzero_count;
  sum_t                 out_freq_total;
  cnt_t                 out_zero_count;
  cnt_t                 out_hot_count;
  cnt_t                 out_white_count;
  cnt_t                 out_bucket_value;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  freq_stats_scoreboard sb;
  bit no_idle;
  bit hold_req;
  int holds_done;
  int settings_used;

  page_access_frequency_stats dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_node           (in_node),
    .in_freq           (in_freq),
    .in_white          (in_white),
    .in_first          (in_first),
    .in_last           (in_last),
    .in_bucket_index   (in_bucket_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_page_count    (out_page_count),
    .out_max_freq      (out_max_freq),
    .out_min_freq      (out_min_freq),
    .out_nonzero_count (out_nonzero_count),
    .out_freq_total    (out_freq_total),
    .out_zero_count    (out_zero_count),
    .out_hot_count     (out_hot_count),
    .out_white_count   (out_white_count),
    .out_bucket_value  (out_bucket_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic page_word_t word_of(logic op, int node, int freq, logic white,
                                         logic first, logic last, int bidx);
    page_word_t w;
    w.op    = op;
    w.node  = NODE_W'(node);
    w.freq  = FREQ_W'(freq);
    w.white = white;
    w.first = first;
    w.last  = last;
    w.bidx  = BIDX_W'(bidx);
    return w;
  endfunction

  // frequencies lean on zero, full scale and the low buckets
  function automatic int pick_freq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 22) return 255;
    if (r < 60) return $urandom_range(1, 20);
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return THR_W'(255);
      3: return THR_W'(256);
      4: return THR_W'($urandom_range(1, 255));
      default: return THR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic page_word_t any_readout();
    return word_of(OP_READ_BUCKET, $urandom_range(0, 7), $urandom_range(0, 255),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom_range(0, 15));
  endfunction

  // offer one word and wait for it to be taken; called and left at a falling edge
  task automatic send_word(input page_word_t w);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) >= 55) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= w.op;
    in_node         <= w.node;
    in_freq         <= w.freq;
    in_white        <= w.white;
    in_first        <= w.first;
    in_last         <= w.last;
    in_bucket_index <= w.bidx;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(w);
    @(negedge clk);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic set_regs(input logic [THR_W-1:0] thr, input logic [LNC_W-1:0] lnc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOT_THRESHOLD;
    cfg_data  <= CFG_W'(thr);
    sb.write_reg(CFG_HOT_THRESHOLD, CFG_W'(thr));
    @(negedge clk);
    cfg_index <= CFG_LOCAL_NODE_COUNT;
    cfg_data  <= CFG_W'(lnc);
    sb.write_reg(CFG_LOCAL_NODE_COUNT, CFG_W'(lnc));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // drop valid, wait for every due word, then let the pipeline empty
  task automatic settle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (sb.pending_figures.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (sb.pending_figures.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending_figures.size()));
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one run on a node, with readouts mixed in and now and then a broken run
  task automatic send_run();
    int len;
    int i;
    int run_node;
    bit drop_first;
    bit drop_last;
    page_word_t w;
    len        = ($urandom_range(0, 99) < 5) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    run_node   = $urandom_range(0, 7);
    drop_first = $urandom_range(0, 99) < 6;
    drop_last  = $urandom_range(0, 99) < 6;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 15) send_word(any_readout());
      if ($urandom_range(0, 99) < 4)
        send_word(word_of(OP_RECORD, $urandom_range(0, 7), $urandom_range(0, 255),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom_range(0, 15)));
      w = word_of(OP_RECORD, ($urandom_range(0, 9) < 8) ? run_node : $urandom_range(0, 7),
                  pick_freq(), $urandom_range(0, 9) < 3, (i == 0) && !drop_first,
                  (i == len - 1) && !drop_last, $urandom_range(0, 15));
      send_word(w);
    end
  endtask

  // receiver: random stalls, and a long hold-off when asked
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // take every result word that is handed over
  always @(posedge clk) begin : monitor
    figures_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.kind          = out_kind;
      got.page_count    = out_page_count;
      got.max_freq      = out_max_freq;
      got.min_freq      = out_min_freq;
      got.nonzero_count = out_nonzero_count;
      got.freq_total    = out_freq_total;
      got.zero_count    = out_zero_count;
      got.hot_count     = out_hot_count;
      got.white_count   = out_white_count;
      got.bucket_value  = out_bucket_value;
      sb.check_word(got);
    end
  end

  // stimulus
  initial begin : stimulus
    int phase;
    int goal;
    int base;
    sb              = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_RECORD;
    in_node         = '0;
    in_freq         = '0;
    in_white        = 1'b0;
    in_first        = 1'b0;
    in_last         = 1'b0;
    in_bucket_index = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_HOT_THRESHOLD;
    cfg_data        = '0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: local whitelisted pages skipped, top bucket clamping, readouts
    set_regs(THR_W'(100), LNC_W'(4));
    send_word(word_of(OP_RECORD, 0, 0, 1'b1, 1'b1, 1'b0, 0));
    send_word(word_of(OP_RECORD, 7, 255, 1'b0, 1'b0, 1'b0, 15));
    send_word(word_of(OP_RECORD, 3, 14, 1'b1, 1'b0, 1'b0, 0));
    send_word(word_of(OP_RECORD, 4, 15, 1'b1, 1'b0, 1'b0, 0));
    send_word(word_of(OP_RECORD, 5, 1, 1'b0, 1'b0, 1'b0, 0));
    send_word(word_of(OP_RECORD, 2, 100, 1'b0, 1'b0, 1'b1, 0));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b0, 1'b0, 0));
    send_word(word_of(OP_READ_BUCKET, 7, 255, 1'b1, 1'b1, 1'b1, 15));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b0, 1'b0, 1));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b0, 1'b0, 14));
    // run of one record, then a record without first that carries it on
    send_word(word_of(OP_RECORD, 6, 128, 1'b1, 1'b1, 1'b1, 0));
    send_word(word_of(OP_RECORD, 1, 99, 1'b0, 1'b0, 1'b1, 0));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b1, 1'b1, 7));
    settle();
    // threshold zero, local node count above the node range
    set_regs('0, '1);
    send_word(word_of(OP_RECORD, 7, 0, 1'b1, 1'b1, 1'b0, 0));
    send_word(word_of(OP_RECORD, 0, 255, 1'b1, 1'b0, 1'b1, 0));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b0, 1'b0, 0));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b0, 1'b0, 15));
    settle();
    // threshold at full scale, every node local
    set_regs('1, LNC_W'(NODES));
    send_word(word_of(OP_RECORD, 7, 200, 1'b1, 1'b1, 1'b0, 0));
    send_word(word_of(OP_RECORD, 0, 1, 1'b0, 1'b0, 1'b0, 0));
    send_word(word_of(OP_RECORD, 3, 0, 1'b0, 1'b0, 1'b1, 0));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b0, 1'b0, 15));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b0, 1'b0, 1));
    send_word(word_of(OP_READ_BUCKET, 0, 0, 1'b0, 1'b0, 1'b0, 0));
    settle();

    // random runs, a fresh register setting per phase
    base = sb.words_in;
    for (phase = 0; phase < PHASES; phase++) begin
      set_regs(pick_threshold(), LNC_W'($urandom_range(0, 15)));
      if (phase == 3) begin
        // receiver holds off while words keep coming, so the block backs up
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (20) begin
          send_word(any_readout());
          send_word(word_of(OP_RECORD, $urandom_range(0, 7), pick_freq(),
                            1'($urandom_range(0, 1)), 1'b1, 1'b1, $urandom_range(0, 15)));
        end
        no_idle = 1'b0;
      end
      if (phase == 5) no_idle = 1'b1;
      goal = base + (phase + 1) * RANDOM_WORDS / PHASES;
      while (sb.words_in < goal) send_run();
      settle();
      no_idle = 1'b0;
    end

    $display("%0d input words in %0d runs; %0d statistics words and %0d bucket readouts checked",
             sb.words_in, sb.runs_begun, sb.stats_checked, sb.readouts_checked);
    $display("%0d register settings, %0d long receiver hold-offs, %0d mismatches",
             settings_used, holds_done, sb.faults);
    if (sb.faults == 0) begin
      $display("[page_access_frequency_stats] OK");
    end else begin
      $display("[page_access_frequency_stats] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #10_000_000;
    $display("run limit reached with %0d result words outstanding",
             sb.pending_figures.size());
    $display("[page_access_frequency_stats] ERROR");
    $finish;
  end

endmodule

FILE: page_access_frequency_stats.f
rtl/core/pafs_pkg.sv
rtl/core/pafs_hist.sv
rtl/core/pafs_stats.sv
rtl/core/page_access_frequency_stats.sv
tb/page_access_frequency_stats_tb.sv
